/* rtl/core/ip_source_learning_table_core_defines.svh */
// assertion helpers for the source learning table
`ifndef IP_SOURCE_LEARNING_TABLE_CORE_DEFINES_SVH
`define IP_SOURCE_LEARNING_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define ISLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("islt check failed");

// next-cycle implication
`define ISLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("islt check failed");

`endif

/* rtl/core/islt_pkg.sv */
`timescale 1ns / 1ps

package islt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int SUM_W           = 17;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [7:0]  VER_IPV4 = 8'h45;
    localparam logic [7:0]  VER_IPV6 = 8'h60;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_KNOWN   = 2'd1,
        ST_NEW     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] outer_ethertype;
        logic [15:0] vlan_tag;
        logic [15:0] inner_ethertype;
        logic [7:0]  version_byte;
        logic [63:0] source_high;
        logic [63:0] source_low;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot;
        logic        is_ipv6;
        logic [11:0] vlan_id;
    } t_result;

    typedef struct packed {
        logic        learn;
        logic        is_ipv6;
        logic [11:0] vlan_id;
        logic [63:0] source_high;
        logic [63:0] source_low;
    } t_job;

    // hash byte weights, byte 0 first; the ipv4 hash uses the first four
    function automatic logic [5:0] weight6(input logic [3:0] k);
        logic [5:0] w;
        unique case (k)
            4'd0:  w = 6'd1;
            4'd1:  w = 6'd2;
            4'd2:  w = 6'd3;
            4'd3:  w = 6'd5;
            4'd4:  w = 6'd7;
            4'd5:  w = 6'd11;
            4'd6:  w = 6'd13;
            4'd7:  w = 6'd17;
            4'd8:  w = 6'd19;
            4'd9:  w = 6'd23;
            4'd10: w = 6'd29;
            4'd11: w = 6'd31;
            4'd12: w = 6'd37;
            4'd13: w = 6'd41;
            4'd14: w = 6'd43;
            4'd15: w = 6'd47;
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/islt_front.sv */
`timescale 1ns / 1ps

module islt_front import islt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_clearing,
    input  logic          i_in_valid,
    input  t_frame        i_in_frame,
    output logic          o_in_stall,
    output logic          o_push,
    output t_job          o_job,
    output logic [IW-1:0] o_idx,
    input  logic          i_full
);

    localparam int RECIP = (2 ** SUM_W) / TABLE_DEPTH;
    localparam logic [SUM_W-1:0] RECIP_V = SUM_W'(RECIP);
    localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(TABLE_DEPTH);

    logic             r_enable;
    logic             r1_v, r2_v;
    t_job             r1_job, r2_job, n1_job;
    logic [SUM_W-1:0] r1_sum, r2_sum, n1_sum, r2_q;
    logic [SUM_W-1:0] sum4, sum6, rem, idx;
    logic [2*SUM_W-1:0] prod1, prod2;
    logic             vlan_frame, is4, is6, learn;
    logic [15:0]      etype;
    logic             adv1, adv2, accept;

    always_comb begin
        vlan_frame = i_in_frame.outer_ethertype == ETH_VLAN;
        etype  = vlan_frame ? i_in_frame.inner_ethertype : i_in_frame.outer_ethertype;
        is4    = (etype == ETH_IPV4) && (i_in_frame.version_byte == VER_IPV4);
        is6    = (etype == ETH_IPV6) && (i_in_frame.version_byte == VER_IPV6);
        learn  = r_enable && (is4 || is6);
        sum4   = '0;
        sum6   = '0;
        for (int k = 0; k < 4; k++) begin
            sum4 = sum4 + SUM_W'(i_in_frame.source_low[31-8*k -: 8])
                        * SUM_W'(weight6(4'(k)));
        end
        for (int k = 0; k < 8; k++) begin
            sum6 = sum6 + SUM_W'(i_in_frame.source_high[63-8*k -: 8])
                        * SUM_W'(weight6(4'(k)));
            sum6 = sum6 + SUM_W'(i_in_frame.source_low[63-8*k -: 8])
                        * SUM_W'(weight6(4'(k + 8)));
        end
        n1_job.learn       = learn;
        n1_job.is_ipv6     = learn && is6;
        n1_job.vlan_id     = vlan_frame ? i_in_frame.vlan_tag[11:0] : 12'd0;
        n1_job.source_high = i_in_frame.source_high;
        n1_job.source_low  = i_in_frame.source_low;
        n1_sum             = is4 ? sum4 : sum6;
    end

    // hash modulo depth: reciprocal estimate, then one correction
    assign prod1 = (2*SUM_W)'(r1_sum) * (2*SUM_W)'(RECIP_V);
    assign prod2 = (2*SUM_W)'(r2_q) * (2*SUM_W)'(DEPTH_V);
    assign rem   = r2_sum - prod2[SUM_W-1:0];
    assign idx   = (rem >= DEPTH_V) ? rem - DEPTH_V : rem;

    assign o_push     = r2_v && !i_full;
    assign adv2       = !r2_v || o_push;
    assign adv1       = !r1_v || adv2;
    assign accept     = i_in_valid && adv1 && !i_clearing;
    assign o_in_stall = !adv1 || i_clearing;
    assign o_job      = r2_job;
    assign o_idx      = idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (adv1) begin
                r1_v <= accept;
            end
            if (adv2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_job <= n1_job;
            r1_sum <= n1_sum;
        end
        if (adv2 && r1_v) begin
            r2_job <= r1_job;
            r2_sum <= r1_sum;
            r2_q   <= prod1[2*SUM_W-1:SUM_W];
        end
    end

endmodule

/* rtl/core/islt_queue.sv */
`timescale 1ns / 1ps

module islt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/core/islt_back.sv */
`timescale 1ns / 1ps
`include "ip_source_learning_table_core_defines.svh"

module islt_back import islt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_job          i_job,
    input  logic [IW-1:0] i_idx,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_out_valid,
    output t_result       o_result,
    input  logic          i_out_stall
);

    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_addr, n_addr, r_last, n_last, rd_addr, next_addr;
    t_job          r_job, n_job;
    logic          r_ov, n_ov;
    t_result       r_res, n_res;

    logic [31:0]   r_mem4  [TABLE_DEPTH];
    logic [63:0]   r_mem6h [TABLE_DEPTH];
    logic [63:0]   r_mem6l [TABLE_DEPTH];
    logic [31:0]   r_rd4;
    logic [63:0]   r_rd6h, r_rd6l;

    logic          we4, we6;
    logic [31:0]   wd4;
    logic [63:0]   wd6h, wd6l;
    logic          out_free, match, empty, done;

    assign next_addr = (r_addr == LAST_SLOT) ? '0 : r_addr + IW'(1);
    assign out_free  = !r_ov || !i_out_stall;

    always_comb begin
        if (r_job.is_ipv6) begin
            match = (r_rd6h == r_job.source_high) && (r_rd6l == r_job.source_low);
            empty = (r_rd6h == 64'd0) && (r_rd6l == 64'd0);
        end else begin
            match = r_rd4 == r_job.source_low[31:0];
            empty = r_rd4 == 32'd0;
        end
        done = match || empty || (r_addr == r_last);
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        n_job   = r_job;
        n_ov    = r_ov && i_out_stall;
        n_res   = r_res;
        rd_addr = r_addr;
        o_pop   = 1'b0;
        we4     = 1'b0;
        we6     = 1'b0;
        wd4     = r_job.source_low[31:0];
        wd6h    = r_job.source_high;
        wd6l    = r_job.source_low;
        unique case (r_state)
            S_CLEAR: begin
                we4    = 1'b1;
                we6    = 1'b1;
                wd4    = '0;
                wd6h   = '0;
                wd6l   = '0;
                n_addr = next_addr;
                if (r_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    if (!i_job.learn) begin
                        n_ov           = 1'b1;
                        n_res.status   = ST_IGNORED;
                        n_res.slot     = 8'd0;
                        n_res.is_ipv6  = 1'b0;
                        n_res.vlan_id  = i_job.vlan_id;
                    end else begin
                        n_addr  = i_idx;
                        n_last  = (i_idx == '0) ? LAST_SLOT : i_idx - IW'(1);
                        rd_addr = i_idx;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (done) begin
                    if (out_free) begin
                        n_ov          = 1'b1;
                        n_res.is_ipv6 = r_job.is_ipv6;
                        n_res.vlan_id = r_job.vlan_id;
                        n_state       = S_IDLE;
                        priority if (match) begin
                            n_res.status = ST_KNOWN;
                            n_res.slot   = 8'(r_addr);
                        end else if (empty) begin
                            n_res.status = ST_NEW;
                            n_res.slot   = 8'(r_addr);
                            we4          = !r_job.is_ipv6;
                            we6          = r_job.is_ipv6;
                        end else begin
                            n_res.status = ST_FULL;
                            n_res.slot   = 8'd0;
                        end
                    end
                end else begin
                    n_addr  = next_addr;
                    rd_addr = next_addr;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ov    <= n_ov;
        end
        r_last <= n_last;
        r_job  <= n_job;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we4) begin
            r_mem4[r_addr] <= wd4;
        end
        if (we6) begin
            r_mem6h[r_addr] <= wd6h;
            r_mem6l[r_addr] <= wd6l;
        end
        r_rd4  <= r_mem4[rd_addr];
        r_rd6h <= r_mem6h[rd_addr];
        r_rd6l <= r_mem6l[rd_addr];
    end

    assign o_clearing  = r_state == S_CLEAR;
    assign o_out_valid = r_ov;
    assign o_result    = r_res;

    `ISLT_ASSERT_NOW(a_write_only_empty4, i_clk, i_rst_n, (r_state == S_PROBE) && we4, r_rd4 == 32'd0)
    `ISLT_ASSERT_NOW(a_write_only_empty6, i_clk, i_rst_n, (r_state == S_PROBE) && we6, (r_rd6h == 64'd0) && (r_rd6l == 64'd0))
    `ISLT_ASSERT_NEXT(a_pop_then_work, i_clk, i_rst_n, o_pop, (r_state == S_PROBE) || r_ov)
    `ISLT_ASSERT_NEXT(a_probe_continues, i_clk, i_rst_n, (r_state == S_PROBE) && !done, r_state == S_PROBE)

endmodule

/* rtl/core/ip_source_learning_table_core.sv */
`timescale 1ns / 1ps
// channel   direction  payload   handshake
// input     in         t_frame   i_in_valid / o_in_stall
// output    out        t_result  o_out_valid / i_out_stall
// config    in         1 bit     i_cfg_we / i_cfg_wdata
//
// a frame passes the hash pipeline registers r1 and r2, then the queue; an ignored frame
// is answered from idle, a learned one probes slot after slot, one read of the table per slot
// the probe engine works on one frame at a time, the frames behind it wait in the queue
// after reset the tables are cleared one slot a cycle, all TABLE_DEPTH slots, input stalled
// a 2-entry queue sits between hash and probe; output stall holds the probe engine

module ip_source_learning_table_core import islt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_in_valid,
    input  t_frame  i_in_frame,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_out_result,
    input  logic    i_out_stall
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int QW = $bits(t_job) + IW;

    logic          push, full, q_valid, pop, clearing;
    t_job          f_job, b_job;
    logic [IW-1:0] f_idx, b_idx;
    logic [QW-1:0] q_out;

    islt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_clearing  (clearing),
        .i_in_valid  (i_in_valid),
        .i_in_frame  (i_in_frame),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (f_job),
        .o_idx       (f_idx),
        .i_full      (full)
    );

    islt_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_job, f_idx}),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign b_job = t_job'(q_out[QW-1:IW]);
    assign b_idx = q_out[IW-1:0];

    islt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (b_job),
        .i_idx       (b_idx),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .o_result    (o_out_result),
        .i_out_stall (i_out_stall)
    );

endmodule
